@@ src/uwcr_pkg.sv @@
// Shared constants, types and register codes for the unaligned word copy realigner.
`default_nettype none

package uwcr_pkg;

   // Width of the byte count register and of the transfer bookkeeping.
   localparam int COUNT_BITS = 16;
   localparam int ADDR_W     = COUNT_BITS + 1;
   localparam int SEEN_W     = ADDR_W - 2;

   // Byte lanes of one 32-bit word.
   localparam int LANES  = 4;
   localparam int LANE_W = 2;
   localparam int WORD_W = 32;

   // Result queue sizing: two free slots are needed before an item is processed.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Configuration port.
   localparam int CSR_IDX_W = 2;

   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [SEEN_W-1:0]     seen_type;
   typedef logic [FIFO_PTR_W-1:0] fifo_ptr_type;
   typedef logic [FIFO_CNT_W-1:0] fifo_cnt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_OFFSET = 2'd0,
      CSR_DEST_OFFSET   = 2'd1,
      CSR_BYTE_COUNT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LANE_W-1:0]     source_offset;
      logic [LANE_W-1:0]     dest_offset;
      logic [COUNT_BITS-1:0] byte_count;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] dest_word;
      logic [LANES-1:0]  byte_enable;
      logic              last;
   } result_type;

   // Up to two results leave the realigner for each processed source word.
   typedef struct packed {
      logic       first;
      logic       second;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

`default_nettype wire

@@ src/uwcr_csr.sv @@
// Configuration registers of the realigner, written through the csr_ channel.
`default_nettype none

module uwcr_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [uwcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [uwcr_pkg::COUNT_BITS-1:0]    csr_data,
   output uwcr_pkg::cfg_type                       cfg
);

   uwcr_pkg::cfg_type cfg_ff;
   uwcr_pkg::cfg_type cfg_in;

   // Writes are always taken; unknown indexes leave the registers alone.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (uwcr_pkg::csr_index_type'(csr_index))
            uwcr_pkg::CSR_SOURCE_OFFSET: cfg_in.source_offset = csr_data[uwcr_pkg::LANE_W-1:0];
            uwcr_pkg::CSR_DEST_OFFSET:   cfg_in.dest_offset   = csr_data[uwcr_pkg::LANE_W-1:0];
            uwcr_pkg::CSR_BYTE_COUNT:    cfg_in.byte_count    = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/uwcr_core.sv @@
// Input register, transfer state and funnel shifter that forms destination words.
`default_nettype none

module uwcr_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [uwcr_pkg::WORD_W-1:0]     req_source_word,
   input  wire logic                            req_start_req,
   input  wire uwcr_pkg::cfg_type               cfg,
   input  wire logic                            fifo_room,
   output uwcr_pkg::push_type                   push
);

   // Gather the enabled lanes of one destination word. Source byte j of the
   // word starts at source address sa; a carry past lane 3 means the byte
   // lives in the current word, otherwise base_cur picks current or held.
   function automatic uwcr_pkg::result_type build_word(
      input logic [uwcr_pkg::WORD_W-1:0] cur,
      input logic [uwcr_pkg::WORD_W-1:0] held,
      input logic                        base_cur,
      input logic [uwcr_pkg::LANE_W-1:0] src_lane,
      input logic [uwcr_pkg::LANE_W-1:0] dst_lane,
      input logic [2:0]                  n
   );
      uwcr_pkg::result_type              r;
      logic [uwcr_pkg::LANE_W-1:0]       j;
      logic [2:0]                        pos;
      logic [uwcr_pkg::WORD_W-1:0]       from;
      r = '0;
      for (int l = 0; l < uwcr_pkg::LANES; l++) begin
         j    = 2'(l) - dst_lane;
         pos  = {1'b0, src_lane} + {1'b0, j};
         from = (pos[2] || base_cur) ? cur : held;
         if ((2'(l) >= dst_lane) && ({1'b0, j} < n)) begin
            r.dest_word[8*l +: 8] = 8'(from >> {pos[1:0], 3'b000});
            r.byte_enable[l]      = 1'b1;
         end
      end
      return r;
   endfunction

   // Input register.
   logic                          in_vld_ff;
   logic [uwcr_pkg::WORD_W-1:0]   in_word_ff;
   logic                          in_start_ff;
   logic                          fire;

   // Transfer state.
   logic                          active_ff,   active_in;
   uwcr_pkg::addr_type            rem_ff,      rem_in;
   uwcr_pkg::addr_type            src_addr_ff, src_addr_in;
   logic [uwcr_pkg::LANE_W-1:0]   dst_lane_ff, dst_lane_in;
   uwcr_pkg::seen_type            seen_ff,     seen_in;
   logic [uwcr_pkg::WORD_W-1:0]   held_ff,     held_in;

   // Effective state for the word being processed (fresh values on a start).
   logic                          eff_active;
   uwcr_pkg::addr_type            eff_rem;
   uwcr_pkg::addr_type            eff_sa;
   logic [uwcr_pkg::LANE_W-1:0]   eff_lane;
   uwcr_pkg::seen_type            eff_seen;

   logic [2:0]                    room1;
   logic [2:0]                    n1;
   logic [2:0]                    n2;
   uwcr_pkg::addr_type            rem1;
   uwcr_pkg::addr_type            sa2;
   uwcr_pkg::addr_type            last1_addr;
   uwcr_pkg::addr_type            last2_addr;
   logic                          go1;
   logic                          go2;
   logic [3:0]                    consumed;
   uwcr_pkg::addr_type            rem_new;

   // The input register frees up whenever the word moves into the realigner.
   assign fire      = in_vld_ff && fifo_room;
   assign req_ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff  <= req_source_word;
         in_start_ff <= req_start_req;
      end
   end

   // A start loads the transfer from the configuration registers.
   always_comb begin
      if (in_start_ff) begin
         eff_active = cfg.byte_count != '0;
         eff_rem    = uwcr_pkg::addr_type'(cfg.byte_count);
         eff_sa     = uwcr_pkg::addr_type'(cfg.source_offset);
         eff_lane   = cfg.dest_offset;
         eff_seen   = '0;
      end else begin
         eff_active = active_ff;
         eff_rem    = rem_ff;
         eff_sa     = src_addr_ff;
         eff_lane   = dst_lane_ff;
         eff_seen   = seen_ff;
      end
   end

   // Sizes of the two candidate destination words; the second one is aligned.
   always_comb begin
      room1      = 3'(uwcr_pkg::LANES) - {1'b0, eff_lane};
      n1         = (eff_rem < uwcr_pkg::addr_type'(room1)) ? eff_rem[2:0] : room1;
      rem1       = eff_rem - uwcr_pkg::addr_type'(n1);
      n2         = (rem1 < uwcr_pkg::addr_type'(uwcr_pkg::LANES)) ?
                   rem1[2:0] : 3'(uwcr_pkg::LANES);
      sa2        = eff_sa + uwcr_pkg::addr_type'(n1);
      last1_addr = sa2 - uwcr_pkg::addr_type'(1);
      last2_addr = eff_sa + uwcr_pkg::addr_type'(n1) + uwcr_pkg::addr_type'(n2)
                   - uwcr_pkg::addr_type'(1);
   end

   // A word goes out once its last source byte has arrived.
   assign go1 = eff_active && (eff_rem != '0) &&
                (last1_addr[uwcr_pkg::ADDR_W-1:2] <= eff_seen);
   assign go2 = go1 && (rem1 != '0) &&
                (last2_addr[uwcr_pkg::ADDR_W-1:2] <= eff_seen);

   always_comb begin
      if (go2) begin
         consumed = 4'(n1) + 4'(n2);
      end else if (go1) begin
         consumed = 4'(n1);
      end else begin
         consumed = '0;
      end
   end

   assign rem_new = eff_rem - uwcr_pkg::addr_type'(consumed);

   // Results handed to the queue.
   always_comb begin
      push.first   = fire && go1;
      push.second  = fire && go2;
      push.r0      = build_word(in_word_ff, held_ff,
                                eff_sa[uwcr_pkg::ADDR_W-1:2] == eff_seen,
                                eff_sa[1:0], eff_lane, n1);
      push.r0.last = rem1 == '0;
      push.r1      = build_word(in_word_ff, held_ff,
                                sa2[uwcr_pkg::ADDR_W-1:2] == eff_seen,
                                sa2[1:0], '0, n2);
      push.r1.last = rem1 == uwcr_pkg::addr_type'(n2);
   end

   // State update for each processed word of an active transfer.
   always_comb begin
      active_in   = active_ff;
      rem_in      = rem_ff;
      src_addr_in = src_addr_ff;
      dst_lane_in = dst_lane_ff;
      seen_in     = seen_ff;
      held_in     = held_ff;
      if (fire) begin
         active_in = eff_active && (rem_new != '0);
         if (eff_active) begin
            rem_in      = rem_new;
            src_addr_in = eff_sa + uwcr_pkg::addr_type'(consumed);
            dst_lane_in = eff_lane + consumed[1:0];
            seen_in     = eff_seen + uwcr_pkg::seen_type'(1);
            held_in     = in_word_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         rem_ff      <= '0;
         src_addr_ff <= '0;
         dst_lane_ff <= '0;
         seen_ff     <= '0;
         held_ff     <= '0;
      end else begin
         active_ff   <= active_in;
         rem_ff      <= rem_in;
         src_addr_ff <= src_addr_in;
         dst_lane_ff <= dst_lane_in;
         seen_ff     <= seen_in;
         held_ff     <= held_in;
      end
   end

endmodule

`default_nettype wire

@@ src/uwcr_rsp_fifo.sv @@
// Small result queue that takes up to two results per cycle and drives the rsp_ channel.
`default_nettype none

module uwcr_rsp_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire uwcr_pkg::push_type    push,
   output logic                       fifo_room,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output uwcr_pkg::result_type       head
);

   uwcr_pkg::result_type   entry_ff [uwcr_pkg::FIFO_DEPTH];
   uwcr_pkg::fifo_ptr_type wr_ptr_ff, wr_ptr_in;
   uwcr_pkg::fifo_ptr_type rd_ptr_ff, rd_ptr_in;
   uwcr_pkg::fifo_cnt_type count_ff,  count_in;
   uwcr_pkg::fifo_ptr_type wr_ptr_next;
   uwcr_pkg::fifo_cnt_type n_push;
   logic                   pop;

   assign rsp_valid   = count_ff != '0;
   assign head        = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign fifo_room   = count_ff <= uwcr_pkg::fifo_cnt_type'(uwcr_pkg::FIFO_DEPTH - 2);
   assign n_push      = uwcr_pkg::fifo_cnt_type'(push.first) +
                        uwcr_pkg::fifo_cnt_type'(push.second);
   assign wr_ptr_next = wr_ptr_ff + uwcr_pkg::fifo_ptr_type'(1);

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push[uwcr_pkg::FIFO_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + uwcr_pkg::fifo_ptr_type'(pop);
      count_in  = count_ff + n_push - uwcr_pkg::fifo_cnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The first result lands at the write pointer, the second one just after it.
   always_ff @(posedge clock) begin
      for (int e = 0; e < uwcr_pkg::FIFO_DEPTH; e++) begin
         if (push.first && (uwcr_pkg::fifo_ptr_type'(e) == wr_ptr_ff)) begin
            entry_ff[e] <= push.r0;
         end else if (push.second && (uwcr_pkg::fifo_ptr_type'(e) == wr_ptr_next)) begin
            entry_ff[e] <= push.r1;
         end
      end
   end

endmodule

`default_nettype wire

@@ src/unaligned_word_copy_realigner.sv @@
// Top level of the copy-engine byte realigner.
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_ready   req_source_word, req_start_req
//   rsp_     out        rsp_valid / rsp_ready   rsp_dest_word, rsp_byte_enable, rsp_last
//   csr_     in         csr_valid / csr_ready   csr_index, csr_data
//
// One source word is taken per cycle unless the result queue lacks room; each word is
// realigned from the input register and its results are written into the result queue.
// A source word that completes two destination words gives two results on rsp_, one after another.
// The four-entry result queue absorbs stalls; input stalls once three slots are in use.
// Reset is synchronous and clears the transfer state, queue and registers at once.
// The csr_ channel is always ready and takes effect at the next start.
`default_nettype none

module unaligned_word_copy_realigner (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [uwcr_pkg::WORD_W-1:0]     req_source_word,
   input  wire logic                            req_start_req,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [uwcr_pkg::WORD_W-1:0]          rsp_dest_word,
   output logic [uwcr_pkg::LANES-1:0]           rsp_byte_enable,
   output logic                                 rsp_last,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [uwcr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [uwcr_pkg::COUNT_BITS-1:0] csr_data
);

   uwcr_pkg::cfg_type    cfg;
   uwcr_pkg::push_type   push;
   uwcr_pkg::result_type head;
   logic                 fifo_room;

   uwcr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   uwcr_core u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_source_word (req_source_word),
      .req_start_req   (req_start_req),
      .cfg             (cfg),
      .fifo_room       (fifo_room),
      .push            (push)
   );

   uwcr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .fifo_room (fifo_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   // Result fields to their ports.
   assign rsp_dest_word   = head.dest_word;
   assign rsp_byte_enable = head.byte_enable;
   assign rsp_last        = head.last;

endmodule

`default_nettype wire

@@ src/uwcr_checker.sv @@
// Port-level checks on the realigner result channel, bound to the top level.
`default_nettype none

module uwcr_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [uwcr_pkg::WORD_W-1:0] rsp_dest_word,
   input wire logic [uwcr_pkg::LANES-1:0]  rsp_byte_enable,
   input wire logic                        rsp_last
);

   // Nothing is offered right after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled transaction stays offered.
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   // A stalled transaction keeps its payload.
   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_dest_word) && $stable(rsp_byte_enable) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   // At least one lane is written, and lanes that are not written read zero.
   a_lanes_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_enable != '0) &&
         (rsp_byte_enable[0] || rsp_dest_word[7:0]   == 8'h00) &&
         (rsp_byte_enable[1] || rsp_dest_word[15:8]  == 8'h00) &&
         (rsp_byte_enable[2] || rsp_dest_word[23:16] == 8'h00) &&
         (rsp_byte_enable[3] || rsp_dest_word[31:24] == 8'h00))
      else $error("disabled lane carries data or no lane enabled");

   // Every word but the last of a transfer runs up to the top lane.
   a_fill_to_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_byte_enable[3])
      else $error("non-final destination word does not reach the top lane");

endmodule

bind unaligned_word_copy_realigner uwcr_checker u_checker (.*);

`default_nettype wire
